// ===== rtl/core/mvt_pkg.sv =====
`default_nettype none

package mvt_pkg;

    localparam int ELEM_W        = 32;
    localparam int MAT_DIM       = 4;
    localparam int IDX_W         = 2;
    localparam int FRAC_BITS_DEF = 16;
    localparam int PROD_W        = 2 * ELEM_W;
    localparam int PAIR_W        = PROD_W + 1;
    localparam int ACC_W         = PROD_W + 2;

    // Input tdata: row, col, element, vec_x, vec_y, vec_z, vec_w, zero pad
    localparam int S_ROW_LSB  = 0;
    localparam int S_COL_LSB  = S_ROW_LSB + IDX_W;
    localparam int S_ELEM_LSB = S_COL_LSB + IDX_W;
    localparam int S_VEC_LSB  = S_ELEM_LSB + ELEM_W;
    localparam int S_USED_W   = S_VEC_LSB + MAT_DIM * ELEM_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = MAT_DIM * ELEM_W;

    localparam logic [IDX_W-1:0] ROW_LAST = IDX_W'(MAT_DIM - 1);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_XFORM = 1'b1
    } op_t;

    typedef logic [MAT_DIM-1:0][ELEM_W-1:0] row_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] row;
    } row_tag_t;

endpackage

`default_nettype wire

// ===== rtl/core/mvt_row_store.sv =====
`default_nettype none

module mvt_row_store (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        adv,
    input  wire                        wr_en,
    input  wire  [mvt_pkg::IDX_W-1:0]  wr_row,
    input  wire  [mvt_pkg::IDX_W-1:0]  wr_col,
    input  wire  [mvt_pkg::ELEM_W-1:0] wr_data,
    input  wire                        rd_en,
    input  wire  [mvt_pkg::IDX_W-1:0]  rd_row,
    output mvt_pkg::row_tag_t          rd_tag,
    output mvt_pkg::row_t              rd_data
);
    import mvt_pkg::*;

    // One matrix row per word, one lane per column
    row_t                      mem [MAT_DIM];
    logic [MAT_DIM*MAT_DIM-1:0] elem_vld_reg;
    row_t                      rd_word_reg;
    logic [MAT_DIM-1:0]        rd_vld_reg;
    row_tag_t                  rd_tag_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row][wr_col] <= wr_data;
        end
        if (adv) begin
            rd_word_reg <= mem[rd_row];
        end
    end

    // Lanes never written since reset read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_vld_reg <= '0;
            rd_vld_reg   <= '0;
            rd_tag_reg   <= '0;
        end else begin
            if (wr_en) begin
                elem_vld_reg[{wr_row, wr_col}] <= 1'b1;
            end
            if (adv) begin
                rd_vld_reg       <= elem_vld_reg[rd_row*MAT_DIM +: MAT_DIM];
                rd_tag_reg.valid <= rd_en;
                rd_tag_reg.row   <= rd_row;
            end
        end
    end

    always_comb begin
        for (int j = 0; j < MAT_DIM; j++) begin
            rd_data[j] = rd_vld_reg[j] ? rd_word_reg[j] : '0;
        end
    end

    assign rd_tag = rd_tag_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mvt_row_mac.sv =====
`default_nettype none

module mvt_row_mac #(
    parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        adv,
    input  mvt_pkg::row_tag_t          in_tag,
    input  mvt_pkg::row_t              in_row,
    input  mvt_pkg::row_t              in_vec,
    output mvt_pkg::row_tag_t          out_tag,
    output logic [mvt_pkg::ELEM_W-1:0] out_comp,
    output logic                       out_sat
);
    import mvt_pkg::*;

    logic signed [PROD_W-1:0] prod_next [MAT_DIM];
    logic signed [PROD_W-1:0] prod_reg  [MAT_DIM];
    logic signed [PAIR_W-1:0] pair_next [2];
    logic signed [PAIR_W-1:0] pair_reg  [2];
    logic signed [ACC_W-1:0]  total;
    logic signed [ACC_W-1:0]  shifted;
    logic                     fits;
    logic [ELEM_W-1:0]        comp_next;
    logic [ELEM_W-1:0]        comp_reg;
    logic                     sat_reg;
    row_tag_t                 mul_tag_reg;
    row_tag_t                 add_tag_reg;
    row_tag_t                 fin_tag_reg;

    always_comb begin
        for (int j = 0; j < MAT_DIM; j++) begin
            prod_next[j] = $signed(in_row[j]) * $signed(in_vec[j]);
        end
        pair_next[0] = PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
        pair_next[1] = PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
    end

    // Floor of the exact row sum, then clip to the 32-bit range
    always_comb begin
        total     = ACC_W'(pair_reg[0]) + ACC_W'(pair_reg[1]);
        shifted   = total >>> FRAC_BITS;
        fits      = (&shifted[ACC_W-1:ELEM_W-1]) || !(|shifted[ACC_W-1:ELEM_W-1]);
        if (fits) begin
            comp_next = shifted[ELEM_W-1:0];
        end else if (shifted[ACC_W-1]) begin
            comp_next = {1'b1, {(ELEM_W-1){1'b0}}};
        end else begin
            comp_next = {1'b0, {(ELEM_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
            pair_reg <= pair_next;
            comp_reg <= comp_next;
            sat_reg  <= !fits;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_tag_reg <= '0;
            add_tag_reg <= '0;
            fin_tag_reg <= '0;
        end else if (adv) begin
            mul_tag_reg <= in_tag;
            add_tag_reg <= mul_tag_reg;
            fin_tag_reg <= add_tag_reg;
        end
    end

    assign out_tag  = fin_tag_reg;
    assign out_comp = comp_reg;
    assign out_sat  = sat_reg;

endmodule

`default_nettype wire

// ===== rtl/core/matrix4_vector_transform_unit.sv =====
`default_nettype none

// Channel   Dir  tdata                                    tuser
// --------  ---  ---------------------------------------  ----------------------
// s_        in   row, col, element, vec_x..vec_w (168b)   op (0 write, 1 xform)
// m_        out  res_x, res_y, res_z, res_w (128b)        saturated
//
// Operation: an element write is stored when it is accepted; a vector
// transform reads one matrix row from the row store per cycle while the pipe
// advances; no new transaction is taken until the last row is being read.
// Reset clears the matrix at once through per-element valid bits, so no
// clearing pass is needed. A result waiting in the output register does not
// stop input; the pipe stalls only when the next finished vector reaches the
// end while the output is still held.
module matrix4_vector_transform_unit #(
    parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    // [1:0] row, [3:2] col, [35:4] element, [67:36] vec_x, [99:68] vec_y,
    // [131:100] vec_z, [163:132] vec_w, [167:164] zero
    input  wire  [mvt_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] op
    input  wire                           s_tuser,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    // [31:0] res_x, [63:32] res_y, [95:64] res_z, [127:96] res_w
    output logic [mvt_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] saturated
    output logic                          m_tuser
);
    import mvt_pkg::*;

    // Pipe advance: hold everything only when a finished vector cannot
    // enter the output register.
    logic                          adv;
    logic                          s_accept;
    logic                          is_xform;

    // Row sequencer
    logic                          seq_active_reg, seq_active_next;
    logic [IDX_W-1:0]              seq_row_reg, seq_row_next;
    row_t                          seq_vec_reg, seq_vec_next;
    row_t                          rd_vec_reg;

    row_tag_t                      rd_tag;
    row_t                          rd_data;
    row_tag_t                      fin_tag;
    logic [ELEM_W-1:0]             fin_comp;
    logic                          fin_sat;

    // Result assembly
    logic [MAT_DIM-2:0][ELEM_W-1:0] part_reg;
    logic                           sat_acc_reg;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]           m_tdata_reg;
    logic                           m_tuser_reg;
    logic                           fin_last;

    assign fin_last = fin_tag.valid && (fin_tag.row == ROW_LAST);
    assign adv      = !(fin_last && m_tvalid_reg && !m_tready);
    assign s_tready = adv && (!seq_active_reg || seq_row_reg == ROW_LAST);
    assign s_accept = s_tvalid && s_tready;
    assign is_xform = (s_tuser == OP_XFORM);

    always_comb begin
        seq_active_next = seq_active_reg;
        seq_row_next    = seq_row_reg;
        seq_vec_next    = seq_vec_reg;
        if (adv) begin
            if (s_accept && is_xform) begin
                seq_active_next = 1'b1;
                seq_row_next    = '0;
                for (int j = 0; j < MAT_DIM; j++) begin
                    seq_vec_next[j] = s_tdata[S_VEC_LSB + j*ELEM_W +: ELEM_W];
                end
            end else if (seq_active_reg) begin
                seq_row_next = seq_row_reg + 1'b1;
                if (seq_row_reg == ROW_LAST) begin
                    seq_active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_active_reg <= 1'b0;
            seq_row_reg    <= '0;
        end else begin
            seq_active_reg <= seq_active_next;
            seq_row_reg    <= seq_row_next;
        end
    end

    // Vector travels beside the row read so a new transaction can load early
    always_ff @(posedge aclk) begin
        seq_vec_reg <= seq_vec_next;
        if (adv) begin
            rd_vec_reg <= seq_vec_reg;
        end
    end

    mvt_row_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .wr_en   (s_accept && !is_xform),
        .wr_row  (s_tdata[S_ROW_LSB +: IDX_W]),
        .wr_col  (s_tdata[S_COL_LSB +: IDX_W]),
        .wr_data (s_tdata[S_ELEM_LSB +: ELEM_W]),
        .rd_en   (seq_active_reg),
        .rd_row  (seq_row_reg),
        .rd_tag  (rd_tag),
        .rd_data (rd_data)
    );

    mvt_row_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_tag   (rd_tag),
        .in_row   (rd_data),
        .in_vec   (rd_vec_reg),
        .out_tag  (fin_tag),
        .out_comp (fin_comp),
        .out_sat  (fin_sat)
    );

    // Collect components; the last row completes the output transaction
    always_ff @(posedge aclk) begin
        if (adv && fin_tag.valid) begin
            if (fin_tag.row != ROW_LAST) begin
                part_reg[fin_tag.row] <= fin_comp;
            end
            sat_acc_reg <= (fin_tag.row == '0) ? fin_sat : (sat_acc_reg || fin_sat);
        end
        if (adv && fin_last) begin
            m_tdata_reg <= {fin_comp, part_reg};
            m_tuser_reg <= sat_acc_reg || fin_sat;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (adv && fin_last) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mvt_checker.sv =====
`default_nettype none

module mvt_checker (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_tvalid,
    input wire                           s_tready,
    input wire  [mvt_pkg::S_TDATA_W-1:0] s_tdata,
    input wire                           s_tuser,
    input wire                           m_tvalid,
    input wire                           m_tready,
    input wire  [mvt_pkg::M_TDATA_W-1:0] m_tdata,
    input wire                           m_tuser
);
    import mvt_pkg::*;

    logic xform_acc;
    assign xform_acc = s_tvalid && s_tready && (s_tuser == OP_XFORM);

    // A transform keeps the input from being ready while its remaining rows are read
    a_xform_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        xform_acc |=> !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("input taken while rows of a transform still pending");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind matrix4_vector_transform_unit mvt_checker u_mvt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
